// ===== design/rtphp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtphp_pkg: shared types and constants of the RTP header parser
// Beat structs for both channels, status codes and fixed header geometry.
// ----------------------------------------------------------------------------
package rtphp_pkg;

  // Input beat: one packet byte in wire order
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // Output beat: a CSRC word or the header summary
  typedef struct packed {
    logic [3:0]  entry;
    logic [1:0]  status;
    logic [1:0]  version;
    logic        padding;
    logic        extension;
    logic        marker;
    logic [6:0]  pt_code;
    logic [3:0]  src_count;
    logic [15:0] sequence_res;
    logic [31:0] timestamp;
    logic [31:0] source_word;
    logic [15:0] payload_offset;
  } out_t;

  // Status codes of a summary beat
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StTooShort  = 2'd1;
  localparam logic [1:0] StBadVer    = 2'd2;
  localparam logic [1:0] StExtTrunc  = 2'd3;

  // Entry code that marks the header summary
  localparam logic [3:0] SummaryEntry = 4'd15;

  // Fixed header geometry
  localparam int unsigned CountW  = 16;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [6:0]  BaseLen = 7'd12;
  localparam logic [1:0]  MaxVer  = 2'd2;

endpackage

// ===== design/rtphp_field_capture.sv =====
// ----------------------------------------------------------------------------
// rtphp_field_capture: per-byte header field capture
// Counts packet bytes, captures fields at fixed offsets, assembles CSRC
// words and builds the summary beat on the last byte.
// ----------------------------------------------------------------------------
module rtphp_field_capture (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  rtphp_pkg::in_t  item_i,
  output logic            res_valid_o,
  output rtphp_pkg::out_t res_o
);
  import rtphp_pkg::*;

  logic [CountW-1:0] byte_count_q, byte_count_d;
  logic [7:0]        first_byte_q, first_byte_d;
  logic [7:0]        second_byte_q, second_byte_d;
  logic [15:0]       sequence_q, sequence_d;
  logic [31:0]       timestamp_q, timestamp_d;
  logic [31:0]       source_q, source_d;
  logic [31:0]       word_shift_q, word_shift_d;
  logic [15:0]       ext_words_q, ext_words_d;

  logic [7:0]        b;
  logic [CountW-1:0] idx;
  logic [CountW-1:0] n;
  logic [6:0]        csrc_end;
  logic [CountW-1:0] csrc_end_w;
  logic              in_csrc;
  logic              have_word;
  logic [4:0]        word_idx;
  logic              xbit;
  logic              ext_full;
  logic [15:0]       ew;
  logic [18:0]       offset;
  logic [1:0]        status;

  assign b   = item_i.data_byte;
  assign idx = byte_count_q;

  // Capture fields at their fixed positions
  always_comb begin
    first_byte_d  = first_byte_q;
    second_byte_d = second_byte_q;
    sequence_d    = sequence_q;
    timestamp_d   = timestamp_q;
    source_d      = source_q;
    if (idx == CountW'(0)) begin
      first_byte_d = b;
    end else if (idx == CountW'(1)) begin
      second_byte_d = b;
    end else if (idx < CountW'(4)) begin
      sequence_d = {sequence_q[7:0], b};
    end else if (idx < CountW'(8)) begin
      timestamp_d = {timestamp_q[23:0], b};
    end else if (idx < CountW'(12)) begin
      source_d = {source_q[23:0], b};
    end
  end

  // CSRC list ends at 12 + 4*CC
  assign csrc_end   = BaseLen + {1'b0, first_byte_d[3:0], 2'b00};
  assign csrc_end_w = CountW'(csrc_end);
  assign in_csrc    = (idx >= CountW'(BaseLen)) && (idx < csrc_end_w);
  assign have_word  = in_csrc && (idx[1:0] == 2'b11);
  assign word_idx   = idx[6:2] - 5'd3;

  always_comb begin
    word_shift_d = word_shift_q;
    ext_words_d  = ext_words_q;
    if (in_csrc) begin
      word_shift_d = {word_shift_q[23:0], b};
    end
    if ((idx == csrc_end_w + CountW'(2)) || (idx == csrc_end_w + CountW'(3))) begin
      ext_words_d = {ext_words_q[7:0], b};
    end
  end

  // Saturating byte count after this byte
  assign n = (byte_count_q == CountMax) ? byte_count_q : byte_count_q + CountW'(1);

  // Summary arithmetic
  assign xbit     = first_byte_d[4];
  assign ext_full = n >= csrc_end_w + CountW'(4);
  assign ew       = ext_full ? ext_words_d : 16'd0;
  assign offset   = 19'(csrc_end) + (xbit ? (19'd4 + {1'b0, ew, 2'b00}) : 19'd0);

  always_comb begin
    if (n < csrc_end_w) begin
      status = StTooShort;
    end else if (first_byte_d[7:6] > MaxVer) begin
      status = StBadVer;
    end else if (xbit && (!ext_full || (19'(n) < offset))) begin
      status = StExtTrunc;
    end else begin
      status = StOk;
    end
  end

  // Result beat
  always_comb begin
    res_o       = '0;
    res_valid_o = 1'b0;
    if (accept_i && item_i.last_byte) begin
      res_valid_o          = 1'b1;
      res_o.entry          = SummaryEntry;
      res_o.status         = status;
      res_o.version        = first_byte_d[7:6];
      res_o.padding        = first_byte_d[5];
      res_o.extension      = first_byte_d[4];
      res_o.src_count      = first_byte_d[3:0];
      if (n >= CountW'(2)) begin
        res_o.marker       = second_byte_d[7];
        res_o.pt_code      = second_byte_d[6:0];
      end
      if (n >= CountW'(4)) begin
        res_o.sequence_res = sequence_d;
      end
      if (n >= CountW'(8)) begin
        res_o.timestamp    = timestamp_d;
      end
      if (n >= CountW'(12)) begin
        res_o.source_word  = source_d;
      end
      res_o.payload_offset = (offset > 19'hFFFF) ? 16'hFFFF : offset[15:0];
    end else if (accept_i && have_word) begin
      res_valid_o       = 1'b1;
      res_o.entry       = word_idx[3:0];
      res_o.source_word = word_shift_d;
    end
  end

  // Restart the count on the last byte; field registers load on each accepted byte
  assign byte_count_d = item_i.last_byte ? '0 : n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
    end else if (accept_i) begin
      byte_count_q <= byte_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      first_byte_q  <= first_byte_d;
      second_byte_q <= second_byte_d;
      sequence_q    <= sequence_d;
      timestamp_q   <= timestamp_d;
      source_q      <= source_d;
      word_shift_q  <= word_shift_d;
      ext_words_q   <= ext_words_d;
    end
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.last_byte |=> byte_count_q == '0)
    else $error("byte count not cleared after last byte");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !item_i.last_byte && (byte_count_q != CountMax)
    |=> byte_count_q == $past(byte_count_q) + CountW'(1))
    else $error("byte count did not advance");

  a_csrc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.entry != SummaryEntry)
    |-> (res_o.status == StOk) && (res_o.payload_offset == 16'd0)
        && (res_o.timestamp == 32'd0))
    else $error("CSRC beat carries summary fields");

endmodule

// ===== design/rtphp_out_buf.sv =====
// ----------------------------------------------------------------------------
// rtphp_out_buf: output register with skid stage
// Holds result beats so the input side keeps flowing while the output
// is stalled, until the skid stage is also full.
// ----------------------------------------------------------------------------
module rtphp_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rtphp_pkg::out_t push_data_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rtphp_pkg::out_t out_data_o
);
  import rtphp_pkg::*;

  logic main_valid_q, main_valid_d;
  logic skid_valid_q, skid_valid_d;
  out_t main_q, main_d;
  out_t skid_q, skid_d;
  logic take;

  assign take = main_valid_q && !out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (take) begin
      // advance skid into the output register
      main_valid_d = skid_valid_q;
      main_d       = skid_q;
      skid_valid_d = 1'b0;
    end
    if (push_i) begin
      if (!main_valid_d) begin
        main_valid_d = 1'b1;
        main_d       = push_data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid holds a beat while output register is empty");

  a_push_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && main_valid_q && !take |=> skid_valid_q)
    else $error("beat lost on push into a stalled output");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && skid_valid_q |=> main_valid_q && !skid_valid_q)
    else $error("skid beat not advanced");

endmodule

// ===== design/rtp_header_parser.sv =====
// ----------------------------------------------------------------------------
// rtp_header_parser: RTP fixed-header parser, one byte per beat
// Extracts the fixed header fields, emits each CSRC word as it completes and
// a header summary with status and payload offset on the last byte.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Beat
//   in       sink       in_valid_i/in_stall_o  rtphp_pkg::in_t  (byte, last flag)
//   out      source     out_valid_o/out_stall_i rtphp_pkg::out_t (CSRC or summary)
//
// One byte is taken every cycle while in_stall_o is low; its result, if any,
// is registered in the output register, or in the skid stage under stall.
// The byte counter and field capture sit between the input handshake and the
// output register; the output register plus a skid stage decouple the sides.
// in_stall_o rises only while both output register and skid stage are full.
// Reset clears the byte counter and both output valid flags.
// ----------------------------------------------------------------------------
module rtp_header_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rtphp_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rtphp_pkg::out_t out_data_o
);
  import rtphp_pkg::*;

  logic accept;
  logic res_valid;
  out_t res;
  logic buf_full;

  // Hold off input only when no slot is left for a result
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !in_stall_o;

  // Count bytes and capture fields; build a result beat combinationally
  rtphp_field_capture u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Register the result beat; a skid stage absorbs one beat under stall
  rtphp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/sv/rtp_header_check.sv =====
// ----------------------------------------------------------------------------
// rtp_header_check: self-checking monitor for the RTP header parser
// Watches both channels, parses every accepted byte into the CSRC and summary
// beats the parser must produce, and compares each output beat field by field.
// ----------------------------------------------------------------------------
module rtp_header_check (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  rtphp_pkg::in_t  in_data_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  rtphp_pkg::out_t out_data_i,
  output int unsigned     pending_o,
  output int unsigned     fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Per-packet parse state
  logic [15:0] byte_cnt;
  logic [7:0]  hdr_b0;
  logic [7:0]  hdr_b1;
  logic [15:0] seq_acc;
  logic [31:0] ts_acc;
  logic [31:0] ssrc_acc;
  logic [31:0] csrc_acc;
  logic [15:0] ext_len;

  rtphp_pkg::out_t parsed_q[$];
  int unsigned     mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic clear_packet();
    byte_cnt = '0;
    hdr_b0   = '0;
    hdr_b1   = '0;
    seq_acc  = '0;
    ts_acc   = '0;
    ssrc_acc = '0;
    csrc_acc = '0;
    ext_len  = '0;
  endtask

  // Advance the parse by one byte and queue the beat it causes, if any.
  task automatic parse_rtp_byte(input rtphp_pkg::in_t beat);
    logic [7:0]      b;
    int unsigned     idx;
    int unsigned     csrc_end;
    int unsigned     n;
    int unsigned     ew;
    int unsigned     offset;
    logic            got_word;
    rtphp_pkg::out_t res;
    b        = beat.data_byte;
    idx      = byte_cnt;
    got_word = 1'b0;
    res      = '0;

    if (idx == 0) hdr_b0 = b;
    else if (idx == 1) hdr_b1 = b;
    else if (idx < 4) seq_acc = {seq_acc[7:0], b};
    else if (idx < 8) ts_acc = {ts_acc[23:0], b};
    else if (idx < rtphp_pkg::BaseLen) ssrc_acc = {ssrc_acc[23:0], b};

    csrc_end = rtphp_pkg::BaseLen + 4 * hdr_b0[3:0];
    if (idx >= rtphp_pkg::BaseLen && idx < csrc_end) begin
      csrc_acc = {csrc_acc[23:0], b};
      if (((idx - rtphp_pkg::BaseLen) & 3) == 3) begin
        got_word        = 1'b1;
        res.entry       = 4'((idx - rtphp_pkg::BaseLen) >> 2);
        res.source_word = csrc_acc;
      end
    end
    if (idx == csrc_end + 2 || idx == csrc_end + 3) ext_len = {ext_len[7:0], b};

    if (byte_cnt != rtphp_pkg::CountMax) byte_cnt = byte_cnt + 1'b1;

    if (beat.last_byte) begin
      n      = byte_cnt;
      // an extension length that never fully arrived counts as zero
      ew     = (n >= csrc_end + 4) ? ext_len : 0;
      offset = csrc_end + (hdr_b0[4] ? 4 + 4 * ew : 0);
      res    = '0;
      res.entry = rtphp_pkg::SummaryEntry;
      if (n < csrc_end) res.status = rtphp_pkg::StTooShort;
      else if (hdr_b0[7:6] > rtphp_pkg::MaxVer) res.status = rtphp_pkg::StBadVer;
      else if (hdr_b0[4] && (n < csrc_end + 4 || n < offset)) begin
        res.status = rtphp_pkg::StExtTrunc;
      end else res.status = rtphp_pkg::StOk;
      res.version    = hdr_b0[7:6];
      res.padding    = hdr_b0[5];
      res.extension  = hdr_b0[4];
      res.src_count  = hdr_b0[3:0];
      if (n >= 2) begin
        res.marker  = hdr_b1[7];
        res.pt_code = hdr_b1[6:0];
      end
      if (n >= 4) res.sequence_res = seq_acc;
      if (n >= 8) res.timestamp = ts_acc;
      if (n >= rtphp_pkg::BaseLen) res.source_word = ssrc_acc;
      res.payload_offset = (offset > 32'hFFFF) ? 16'hFFFF : 16'(offset);
      parsed_q.push_back(res);
      clear_packet();
    end else if (got_word) begin
      parsed_q.push_back(res);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Compare before parsing: an output beat at this edge stems from an
  // earlier input beat, never from the one accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    rtphp_pkg::out_t want;
    if (!rst_ni) begin
      clear_packet();
      parsed_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (parsed_q.size() == 0) begin
          $display("%0t: unexpected beat: expected none, actual %h", $time, out_data_i);
          mismatches++;
        end else begin
          want = parsed_q.pop_front();
          check_field("entry", want.entry, out_data_i.entry);
          check_field("status", want.status, out_data_i.status);
          check_field("version", want.version, out_data_i.version);
          check_field("padding", want.padding, out_data_i.padding);
          check_field("extension", want.extension, out_data_i.extension);
          check_field("marker", want.marker, out_data_i.marker);
          check_field("pt_code", want.pt_code, out_data_i.pt_code);
          check_field("src_count", want.src_count, out_data_i.src_count);
          check_field("sequence_res", want.sequence_res, out_data_i.sequence_res);
          check_field("timestamp", want.timestamp, out_data_i.timestamp);
          check_field("source_word", want.source_word, out_data_i.source_word);
          check_field("payload_offset", want.payload_offset, out_data_i.payload_offset);
        end
      end
      if (in_valid_i && !in_stall_i) parse_rtp_byte(in_data_i);
    end
    pending_o <= parsed_q.size();
  end

endmodule

// ===== tb/sv/tb_rtp_header_parser.sv =====
// ----------------------------------------------------------------------------
// tb_rtp_header_parser: testbench top for the RTP header parser
// Feeds directed and random RTP packets byte by byte with random idling on
// both channels; a separate monitor predicts and checks every output beat.
// ----------------------------------------------------------------------------
module tb_rtp_header_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomBytes  = 1500;   // stop the random part here
  localparam int unsigned CalmBytes    = 1200;   // no idling after this point
  localparam int unsigned RxHoldCycles = 80;     // long receiver hold-off
  localparam int unsigned TailCycles   = 20;     // settle time after draining

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  rtphp_pkg::in_t  in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  rtphp_pkg::out_t out_data;

  int unsigned pending;
  int unsigned fail_count;

  logic [7:0]  pkt_q[$];       // bytes of the packet being sent
  int unsigned bytes_sent = 0; // random-part bytes
  bit          calm       = 1'b0;
  bit          hold_rx    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rtp_header_parser i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  rtp_header_check i_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Drive the packet in pkt_q, flag its final byte, and hold each beat until
  // the parser takes it. Idle gaps fall before any byte, first and last too.
  task automatic send_packet(input bit counted);
    foreach (pkt_q[k]) begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= {pkt_q[k], 1'(k == pkt_q.size() - 1)};
      @(posedge clk);
      while (in_stall) @(posedge clk);
      if (counted) bytes_sent++;
    end
  endtask

  // Build a mostly well-formed RTP packet: fixed header, CSRC list, optional
  // extension, some payload. Every so often cut it short at a random byte.
  task automatic make_rtp_packet(input bit full_csrc);
    logic [1:0]  ver;
    logic [3:0]  cc;
    logic        xbit;
    logic [15:0] ext_words;
    int unsigned cut;
    ver  = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : 2'd2;
    xbit = 1'($urandom_range(0, 1));
    if (full_csrc) cc = 4'hF;
    else if ($urandom_range(0, 3) == 0) cc = 4'($urandom_range(0, 15));
    else cc = 4'($urandom_range(0, 3));
    pkt_q.delete();
    pkt_q.push_back({ver, 1'($urandom_range(0, 1)), xbit, cc});
    repeat (11 + 4 * cc) pkt_q.push_back(8'($urandom));
    if (xbit) begin
      // mostly short extensions that fit; sometimes a huge length word
      ext_words = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      pkt_q.push_back(8'($urandom));
      pkt_q.push_back(8'($urandom));
      pkt_q.push_back(ext_words[15:8]);
      pkt_q.push_back(ext_words[7:0]);
      if (ext_words < 8) repeat (4 * ext_words) pkt_q.push_back(8'($urandom));
    end
    repeat ($urandom_range(0, 16)) pkt_q.push_back(8'($urandom));
    if (!full_csrc && $urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, pkt_q.size());
      while (pkt_q.size() > cut) void'(pkt_q.pop_back());
    end
  endtask

  initial begin : rx_side
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        // hold off long enough for the parser to fill and stall its input
        out_stall <= 1'b1;
        repeat (RxHoldCycles) @(posedge clk);
        hold_rx = 1'b0;
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned pkt_num;
    pkt_num = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single byte: nothing past byte 0 arrives, all-ones version and flags.
    pkt_q.delete();
    pkt_q.push_back(8'hFF);
    send_packet(1'b0);

    // Two bytes: marker and payload type at their extremes, rest unreceived.
    pkt_q.delete();
    pkt_q.push_back(8'h00);
    pkt_q.push_back(8'hFF);
    send_packet(1'b0);

    // One CSRC word completed by the final byte; bad version wins over the
    // missing extension.
    pkt_q.delete();
    pkt_q.push_back(8'hD1);
    for (int i = 1; i < 16; i++) pkt_q.push_back(i[0] ? 8'hFF : 8'h00);
    send_packet(1'b0);

    // Sequence number complete, everything after it missing.
    pkt_q.delete();
    pkt_q.push_back(8'h80);
    pkt_q.push_back(8'h00);
    pkt_q.push_back(8'hFF);
    pkt_q.push_back(8'hFF);
    send_packet(1'b0);

    while (bytes_sent < RandomBytes) begin
      pkt_num++;
      if (pkt_num == 10) begin
        // fifteen CSRC words against a receiver that holds off
        hold_rx = 1'b1;
        make_rtp_packet(1'b1);
        send_packet(1'b1);
      end else if ($urandom_range(0, 3) == 0) begin
        // noise: random bytes of random length
        pkt_q.delete();
        repeat ($urandom_range(1, 40)) pkt_q.push_back(8'($urandom));
        send_packet(1'b1);
      end else begin
        make_rtp_packet(1'b0);
        send_packet(1'b1);
      end
      if (pkt_num == 15) begin
        // pause the sender until every pending beat is out
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (bytes_sent >= CalmBytes) calm = 1'b1;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
design/rtphp_pkg.sv
design/rtphp_field_capture.sv
design/rtphp_out_buf.sv
design/rtp_header_parser.sv
tb/sv/rtp_header_check.sv
tb/sv/tb_rtp_header_parser.sv
